FILE: design/rv32_pkg.sv
// Package for the RV32IMC execute block: status codes, opcodes, types.
// No dependencies.
`default_nettype none
package rv32_pkg;

  localparam int unsigned RegCount = 32;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_READ    = 3'd1,
    ST_WRITE   = 3'd2,
    ST_ECALL   = 3'd3,
    ST_ILLEGAL = 3'd4,
    ST_FAULT   = 3'd5,
    ST_STRAY   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PK_LB  = 3'd0,
    PK_LH  = 3'd1,
    PK_LW  = 3'd2,
    PK_LBU = 3'd3,
    PK_LHU = 3'd4,
    PK_ST  = 3'd5
  } pkind_e;

  localparam logic [0:0] CMD_EXEC = 1'b0;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [31:0] INSN_ECALL = 32'h0000_0073;

  // Operation codes that the decoder hands to the datapath
  typedef enum logic [3:0] {
    AOP_ADD, AOP_SUB, AOP_SLL, AOP_SLT, AOP_SLTU, AOP_XOR,
    AOP_SRL, AOP_SRA, AOP_OR, AOP_AND, AOP_PASSB, AOP_MUL
  } aop_e;

  typedef enum logic [2:0] {
    BR_NONE, BR_EQ, BR_NE, BR_LT, BR_GE, BR_LTU, BR_GEU, BR_ALWAYS
  } br_e;

  // Decoded instruction
  typedef struct packed {
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  rd;
    logic        wr_en;
    logic        b_imm;      // operand b is imm
    logic        a_pc;       // operand a is pc
    logic [31:0] imm;
    aop_e        aop;
    logic [2:0]  mfunc;      // M-extension funct3
    logic        is_div;
    br_e         br;
    logic        jalr;       // target = (rs1 + imm) & ~1
    logic        link;       // rd gets pc + size
    logic        load;
    logic        store;
    pkind_e      lkind;
    logic [2:0]  size;
    status_e     st;
    logic        comp;
  } dec_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DIV, S_DIVFIX, S_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take_in;
    logic exec;
    logic mul_go;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_resp;
    logic is_mul;
    logic is_div;
    logic div_last;
  } sts_t;

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: design/rv32_decode.sv
// Instruction decoder for base and compressed RV32IMC encodings.
// Uses rv32_pkg.
`default_nettype none
module rv32_decode (
  input  logic [31:0]       insn_i,
  output rv32_pkg::dec_t    dec_o
);
  import rv32_pkg::*;

  logic [6:0]  op;
  logic [2:0]  f3, cf3;
  logic [6:0]  f7;
  logic [4:0]  crd, rs2c, p1, p2;
  logic [31:0] ci, jo, bo, wo, i4, i16, ilui, lwsp, swsp;

  always_comb begin
    op = insn_i[6:0];
    f3 = insn_i[14:12];
    f7 = insn_i[31:25];
    cf3 = insn_i[15:13];
    crd = insn_i[11:7];
    rs2c = insn_i[6:2];
    p1 = {2'b01, insn_i[9:7]};
    p2 = {2'b01, insn_i[4:2]};
    ci = {{26{insn_i[12]}}, insn_i[12], insn_i[6:2]};
    jo = {{21{insn_i[12]}}, insn_i[8], insn_i[10:9], insn_i[6], insn_i[7], insn_i[2],
          insn_i[11], insn_i[5:3], 1'b0};
    bo = {{24{insn_i[12]}}, insn_i[6:5], insn_i[2], insn_i[11:10], insn_i[4:3], 1'b0};
    wo = {25'd0, insn_i[5], insn_i[12:10], insn_i[6], 2'b00};
    i4 = {22'd0, insn_i[10:7], insn_i[12:11], insn_i[5], insn_i[6], 2'b00};
    i16 = {{23{insn_i[12]}}, insn_i[4:3], insn_i[5], insn_i[2], insn_i[6], 4'd0};
    ilui = {{15{insn_i[12]}}, insn_i[6:2], 12'd0};
    lwsp = {24'd0, insn_i[3:2], insn_i[12], insn_i[6:4], 2'b00};
    swsp = {24'd0, insn_i[8:7], insn_i[12:9], 2'b00};

    dec_o = '0;
    dec_o.aop = AOP_ADD;
    dec_o.br = BR_NONE;
    dec_o.lkind = PK_LB;
    dec_o.st = ST_DONE;

    if (insn_i[1:0] == 2'b11) begin
      dec_o.rs1 = insn_i[19:15];
      dec_o.rs2 = insn_i[24:20];
      dec_o.rd = insn_i[11:7];
      dec_o.imm = sx12(insn_i[31:20]);
      case (op)
        OP_LUI: begin
          dec_o.wr_en = 1'b1; dec_o.b_imm = 1'b1; dec_o.aop = AOP_PASSB;
          dec_o.imm = {insn_i[31:12], 12'd0};
        end
        OP_AUIPC: begin
          dec_o.wr_en = 1'b1; dec_o.b_imm = 1'b1; dec_o.a_pc = 1'b1;
          dec_o.imm = {insn_i[31:12], 12'd0};
        end
        OP_JAL: begin
          dec_o.link = 1'b1; dec_o.br = BR_ALWAYS;
          dec_o.imm = {{12{insn_i[31]}}, insn_i[19:12], insn_i[20], insn_i[30:21], 1'b0};
        end
        OP_JALR: begin
          if (f3 != 3'd0) dec_o.st = ST_ILLEGAL;
          else begin
            dec_o.link = 1'b1; dec_o.jalr = 1'b1;
          end
        end
        OP_BRANCH: begin
          dec_o.imm = {{20{insn_i[31]}}, insn_i[7], insn_i[30:25], insn_i[11:8], 1'b0};
          case (f3)
            3'd0: dec_o.br = BR_EQ;
            3'd1: dec_o.br = BR_NE;
            3'd4: dec_o.br = BR_LT;
            3'd5: dec_o.br = BR_GE;
            3'd6: dec_o.br = BR_LTU;
            3'd7: dec_o.br = BR_GEU;
            default: dec_o.st = ST_ILLEGAL;
          endcase
        end
        OP_LOAD: begin
          case (f3)
            3'd0: begin dec_o.lkind = PK_LB; dec_o.size = 3'd1; end
            3'd1: begin dec_o.lkind = PK_LH; dec_o.size = 3'd2; end
            3'd2: begin dec_o.lkind = PK_LW; dec_o.size = 3'd4; end
            3'd4: begin dec_o.lkind = PK_LBU; dec_o.size = 3'd1; end
            3'd5: begin dec_o.lkind = PK_LHU; dec_o.size = 3'd2; end
            default: dec_o.st = ST_ILLEGAL;
          endcase
          dec_o.load = (dec_o.st == ST_DONE);
          dec_o.b_imm = 1'b1;
        end
        OP_STORE: begin
          dec_o.imm = sx12({insn_i[31:25], insn_i[11:7]});
          dec_o.b_imm = 1'b1;
          case (f3)
            3'd0: dec_o.size = 3'd1;
            3'd1: dec_o.size = 3'd2;
            3'd2: dec_o.size = 3'd4;
            default: dec_o.st = ST_ILLEGAL;
          endcase
          dec_o.store = (dec_o.st == ST_DONE);
        end
        OP_IMM: begin
          dec_o.b_imm = 1'b1;
          if ((f3 == 3'd1 && f7 != 7'd0) ||
              (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20)) dec_o.st = ST_ILLEGAL;
          else begin
            dec_o.wr_en = 1'b1;
            case (f3)
              3'd0: dec_o.aop = AOP_ADD;
              3'd1: dec_o.aop = AOP_SLL;
              3'd2: dec_o.aop = AOP_SLT;
              3'd3: dec_o.aop = AOP_SLTU;
              3'd4: dec_o.aop = AOP_XOR;
              3'd5: dec_o.aop = f7[5] ? AOP_SRA : AOP_SRL;
              3'd6: dec_o.aop = AOP_OR;
              default: dec_o.aop = AOP_AND;
            endcase
          end
        end
        OP_REG: begin
          dec_o.mfunc = f3;
          if (f7 == 7'h01) begin
            dec_o.wr_en = 1'b1;
            dec_o.aop = AOP_MUL;
            dec_o.is_div = f3[2];
          end else if (f7 == 7'd0 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) begin
            dec_o.wr_en = 1'b1;
            case (f3)
              3'd0: dec_o.aop = f7[5] ? AOP_SUB : AOP_ADD;
              3'd1: dec_o.aop = AOP_SLL;
              3'd2: dec_o.aop = AOP_SLT;
              3'd3: dec_o.aop = AOP_SLTU;
              3'd4: dec_o.aop = AOP_XOR;
              3'd5: dec_o.aop = f7[5] ? AOP_SRA : AOP_SRL;
              3'd6: dec_o.aop = AOP_OR;
              default: dec_o.aop = AOP_AND;
            endcase
          end else dec_o.st = ST_ILLEGAL;
        end
        OP_SYSTEM: dec_o.st = (insn_i == INSN_ECALL) ? ST_ECALL : ST_ILLEGAL;
        default: dec_o.st = ST_ILLEGAL;
      endcase
    end else begin
      // Compressed forms
      dec_o.comp = 1'b1;
      case (insn_i[1:0])
        2'b00: begin
          case (cf3)
            3'd0: begin
              dec_o.rs1 = 5'd2; dec_o.rd = p2; dec_o.imm = i4; dec_o.b_imm = 1'b1;
              if (i4 == 32'd0) dec_o.st = ST_ILLEGAL; else dec_o.wr_en = 1'b1;
            end
            3'd2: begin
              dec_o.rs1 = p1; dec_o.rd = p2; dec_o.imm = wo; dec_o.b_imm = 1'b1;
              dec_o.load = 1'b1; dec_o.lkind = PK_LW; dec_o.size = 3'd4;
            end
            3'd6: begin
              dec_o.rs1 = p1; dec_o.rs2 = p2; dec_o.imm = wo; dec_o.b_imm = 1'b1;
              dec_o.store = 1'b1; dec_o.size = 3'd4;
            end
            default: dec_o.st = ST_ILLEGAL;
          endcase
        end
        2'b01: begin
          case (cf3)
            3'd0: begin
              dec_o.rs1 = crd; dec_o.rd = crd; dec_o.imm = ci; dec_o.b_imm = 1'b1;
              dec_o.wr_en = 1'b1;
            end
            3'd1: begin
              dec_o.rd = 5'd1; dec_o.link = 1'b1; dec_o.br = BR_ALWAYS; dec_o.imm = jo;
            end
            3'd2: begin
              dec_o.rd = crd; dec_o.imm = ci; dec_o.b_imm = 1'b1; dec_o.aop = AOP_PASSB;
              dec_o.wr_en = 1'b1;
            end
            3'd3: begin
              if (crd == 5'd2) begin
                dec_o.rs1 = 5'd2; dec_o.rd = 5'd2; dec_o.imm = i16; dec_o.b_imm = 1'b1;
                if (i16 == 32'd0) dec_o.st = ST_ILLEGAL; else dec_o.wr_en = 1'b1;
              end else begin
                dec_o.rd = crd; dec_o.imm = ilui; dec_o.b_imm = 1'b1;
                dec_o.aop = AOP_PASSB;
                if (ilui == 32'd0) dec_o.st = ST_ILLEGAL; else dec_o.wr_en = 1'b1;
              end
            end
            3'd4: begin
              dec_o.rs1 = p1; dec_o.rd = p1; dec_o.rs2 = p2;
              case (insn_i[11:10])
                2'd0, 2'd1: begin
                  dec_o.imm = {27'd0, rs2c}; dec_o.b_imm = 1'b1;
                  dec_o.aop = insn_i[10] ? AOP_SRA : AOP_SRL;
                  if (insn_i[12]) dec_o.st = ST_ILLEGAL; else dec_o.wr_en = 1'b1;
                end
                2'd2: begin
                  dec_o.imm = ci; dec_o.b_imm = 1'b1; dec_o.aop = AOP_AND;
                  dec_o.wr_en = 1'b1;
                end
                default: begin
                  case (insn_i[6:5])
                    2'd0: dec_o.aop = AOP_SUB;
                    2'd1: dec_o.aop = AOP_XOR;
                    2'd2: dec_o.aop = AOP_OR;
                    default: dec_o.aop = AOP_AND;
                  endcase
                  if (insn_i[12]) dec_o.st = ST_ILLEGAL; else dec_o.wr_en = 1'b1;
                end
              endcase
            end
            3'd5: begin dec_o.br = BR_ALWAYS; dec_o.imm = jo; end
            3'd6: begin dec_o.rs1 = p1; dec_o.br = BR_EQ; dec_o.imm = bo; end
            default: begin dec_o.rs1 = p1; dec_o.br = BR_NE; dec_o.imm = bo; end
          endcase
        end
        default: begin
          case (cf3)
            3'd0: begin
              dec_o.rs1 = crd; dec_o.rd = crd; dec_o.imm = {27'd0, rs2c};
              dec_o.b_imm = 1'b1; dec_o.aop = AOP_SLL;
              if (crd == 5'd0 || insn_i[12]) dec_o.st = ST_ILLEGAL;
              else dec_o.wr_en = 1'b1;
            end
            3'd2: begin
              dec_o.rs1 = 5'd2; dec_o.rd = crd; dec_o.imm = lwsp; dec_o.b_imm = 1'b1;
              dec_o.lkind = PK_LW; dec_o.size = 3'd4;
              if (crd == 5'd0) dec_o.st = ST_ILLEGAL; else dec_o.load = 1'b1;
            end
            3'd4: begin
              dec_o.rs1 = crd; dec_o.rs2 = rs2c;
              if (rs2c != 5'd0) begin
                dec_o.rd = crd; dec_o.wr_en = 1'b1;
                if (!insn_i[12]) begin
                  dec_o.rs1 = 5'd0;  // c.mv: 0 + rs2
                end
              end else if (crd == 5'd0) dec_o.st = ST_ILLEGAL;
              else begin
                dec_o.jalr = 1'b1;
                if (insn_i[12]) begin
                  dec_o.link = 1'b1; dec_o.rd = 5'd1;
                end
              end
            end
            3'd6: begin
              dec_o.rs1 = 5'd2; dec_o.rs2 = rs2c; dec_o.imm = swsp; dec_o.b_imm = 1'b1;
              dec_o.store = 1'b1; dec_o.size = 3'd4;
            end
            default: dec_o.st = ST_ILLEGAL;
          endcase
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/rv32_datapath.sv
// Datapath: register file, pc, ALU, multiplier, serial divider, result regs.
// Uses rv32_pkg and rv32_decode.
`default_nettype none
module rv32_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rv32_pkg::cmd_t      cmd_i,
  output rv32_pkg::sts_t      sts_o,
  input  logic                cmd_in_i,
  input  logic [31:0]         instruction_i,
  input  logic [31:0]         read_data_i,
  input  logic                access_ok_i,
  output logic [2:0]          status_o,
  output logic [31:0]         access_address_o,
  output logic [2:0]          access_size_o,
  output logic [31:0]         write_data_o,
  output logic [31:0]         next_pc_o
);
  import rv32_pkg::*;

  logic [31:0] rf_q [RegCount];
  logic [31:0] pc_q, pc_d;
  logic        pend_q;
  logic [4:0]  pdest_q;
  pkind_e      pkind_q;
  logic        resp_q, ok_q;
  logic [31:0] insn_q, rdata_q;
  dec_t        dec;
  logic [31:0] a, b, opa, opb, alu_r, sum;
  logic [31:0] res_q;
  logic [63:0] prod_q;
  logic [32:0] ma, mb;
  // divider: dd_q shifts the dividend out and the quotient in, dv_q is |divisor|
  logic [31:0] dq_q, dr_q, dd_q, dv_q;
  logic [4:0]  dcnt_q;
  logic [33:0] trial;
  logic        qneg_q, rneg_q;
  logic        wr_en;
  logic [4:0]  wr_addr;
  logic [31:0] wr_data;
  logic [31:0] ldv;
  logic        take;

  rv32_decode u_dec (.insn_i(insn_q), .dec_o(dec));

  function automatic logic [31:0] rd_reg(input logic [4:0] i, input logic [31:0] v);
    return (i != 5'd0 && 32'(i) < RegCount) ? v : 32'd0;
  endfunction

  always_comb begin
    a = rd_reg(dec.rs1, rf_q[dec.rs1[$clog2(RegCount)-1:0]]);
    b = rd_reg(dec.rs2, rf_q[dec.rs2[$clog2(RegCount)-1:0]]);
    opa = dec.a_pc ? pc_q : a;
    opb = dec.b_imm ? dec.imm : b;
    sum = opa + opb;
    case (dec.aop)
      AOP_ADD:   alu_r = sum;
      AOP_SUB:   alu_r = opa - opb;
      AOP_SLL:   alu_r = opa << opb[4:0];
      AOP_SLT:   alu_r = {31'd0, $signed(opa) < $signed(opb)};
      AOP_SLTU:  alu_r = {31'd0, opa < opb};
      AOP_XOR:   alu_r = opa ^ opb;
      AOP_SRL:   alu_r = opa >> opb[4:0];
      AOP_SRA:   alu_r = 32'($signed(opa) >>> opb[4:0]);
      AOP_OR:    alu_r = opa | opb;
      AOP_AND:   alu_r = opa & opb;
      AOP_PASSB: alu_r = opb;
      default:   alu_r = sum;
    endcase
    case (dec.br)
      BR_EQ:     take = a == b;
      BR_NE:     take = a != b;
      BR_LT:     take = $signed(a) < $signed(b);
      BR_GE:     take = $signed(a) >= $signed(b);
      BR_LTU:    take = a < b;
      BR_GEU:    take = a >= b;
      BR_ALWAYS: take = 1'b1;
      default:   take = 1'b0;
    endcase
    if (dec.comp && (dec.br == BR_EQ || dec.br == BR_NE)) begin
      take = (dec.br == BR_EQ) ? (a == 32'd0) : (a != 32'd0);
    end
    // multiplier operands: sign-extend per funct3
    ma = {(dec.mfunc == 3'd1 || dec.mfunc == 3'd2) & a[31], a};
    mb = {(dec.mfunc == 3'd1) & b[31], b};
    // shifted partial remainder minus divisor; bit 33 is the borrow
    trial = {1'b0, dr_q, dd_q[31]} - {2'b00, dv_q};
    // load extension
    case (pkind_q)
      PK_LB:   ldv = {{24{rdata_q[7]}}, rdata_q[7:0]};
      PK_LH:   ldv = {{16{rdata_q[15]}}, rdata_q[15:0]};
      PK_LBU:  ldv = {24'd0, rdata_q[7:0]};
      PK_LHU:  ldv = {16'd0, rdata_q[15:0]};
      default: ldv = rdata_q;
    endcase
    // writeback select
    wr_en = 1'b0; wr_addr = dec.rd; wr_data = alu_r; pc_d = pc_q;
    if (cmd_i.exec) begin
      pc_d = pc_q + (dec.comp ? 32'd2 : 32'd4);
      if (dec.jalr) pc_d = (a + dec.imm) & ~32'd1;
      else if (take) pc_d = pc_q + dec.imm;
      if (dec.link) begin
        wr_en = 1'b1; wr_data = pc_q + (dec.comp ? 32'd2 : 32'd4);
      end else if (dec.wr_en && dec.aop != AOP_MUL) wr_en = 1'b1;
    end else if (cmd_i.finish && !resp_q && dec.aop == AOP_MUL && dec.wr_en) begin
      wr_en = 1'b1; wr_data = res_q;
    end else if (cmd_i.exec == 1'b0 && cmd_i.finish && resp_q && pend_q && ok_q
                 && pkind_q != PK_ST) begin
      wr_en = 1'b1; wr_addr = pdest_q; wr_data = ldv;
    end
  end

  // b == 0 and signed overflow checks for divider edge cases
  logic bz_q, ovf_q;
  logic [31:0] a_q;

  // Input capture, register file and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) rf_q[i] <= '0;
      pc_q <= '0;
      pend_q <= 1'b0;
      pdest_q <= '0;
      pkind_q <= PK_LB;
      resp_q <= 1'b0;
    end else begin
      if (cmd_i.take_in) resp_q <= cmd_in_i;
      if (wr_en && wr_addr != 5'd0 && 32'(wr_addr) < RegCount)
        rf_q[wr_addr[$clog2(RegCount)-1:0]] <= wr_data;
      pc_q <= pc_d;
      if (cmd_i.exec) begin
        pend_q <= dec.st == ST_DONE && (dec.load || dec.store);
        pdest_q <= dec.load ? dec.rd : 5'd0;
        pkind_q <= dec.load ? dec.lkind : PK_ST;
      end else if (cmd_i.finish && resp_q) pend_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      insn_q <= instruction_i;
      rdata_q <= read_data_i;
      ok_q <= access_ok_i;
    end
    if (cmd_i.mul_go) prod_q <= 64'($signed(ma) * $signed(mb));
    if (cmd_i.div_start) begin
      bz_q <= (b == 32'd0);
      ovf_q <= (a == 32'h8000_0000) && (b == 32'hffff_ffff) && !dec.mfunc[0];
      a_q <= a;
      qneg_q <= !dec.mfunc[0] && (a[31] ^ b[31]);
      rneg_q <= !dec.mfunc[0] && a[31];
      dd_q <= (!dec.mfunc[0] && a[31]) ? -a : a;
      dv_q <= (!dec.mfunc[0] && b[31]) ? -b : b;
      dr_q <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      // restoring step: subtract when the shifted remainder covers the divisor
      if (!trial[33]) begin
        dr_q <= trial[31:0];
        dd_q <= {dd_q[30:0], 1'b1};
      end else begin
        dr_q <= {dr_q[30:0], dd_q[31]};
        dd_q <= {dd_q[30:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 5'd1;
    end
    if (cmd_i.exec) res_q <= alu_r;
    else if (cmd_i.mul_go) res_q <= '0;
    else if (sts_o.is_mul && !dec.is_div && !cmd_i.div_step && !cmd_i.finish)
      res_q <= (dec.mfunc == 3'd0) ? prod_q[31:0] : prod_q[63:32];
    else if (sts_o.is_div && !cmd_i.div_step && !cmd_i.div_start && !cmd_i.finish) begin
      if (bz_q) res_q <= dec.mfunc[1] ? a_q : 32'hffff_ffff;
      else if (ovf_q) res_q <= dec.mfunc[1] ? 32'd0 : a_q;
      else if (dec.mfunc[1]) res_q <= rneg_q ? -dr_q : dr_q;
      else res_q <= qneg_q ? -dd_q : dd_q;
    end
  end

  // Result registers: captured during the exec step or when a response item is taken in, held for output
  logic [2:0]  st_q, sz_q;
  logic [31:0] ad_q, wd_q;
  logic [31:0] bm;
  assign bm = b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (dec.st != ST_DONE) st_q <= dec.st;
      else if (dec.load) st_q <= ST_READ;
      else if (dec.store) st_q <= ST_WRITE;
      else st_q <= ST_DONE;
      if (dec.st == ST_DONE && (dec.load || dec.store)) begin
        ad_q <= sum; sz_q <= dec.size;
        wd_q <= !dec.store ? 32'd0 : (dec.size == 3'd1) ? {24'd0, bm[7:0]} :
                (dec.size == 3'd2) ? {16'd0, bm[15:0]} : bm;
      end else begin
        ad_q <= '0; sz_q <= '0; wd_q <= '0;
      end
    end else if (cmd_i.take_in && cmd_in_i) begin
      st_q <= !pend_q ? ST_STRAY : (!access_ok_i ? ST_FAULT : ST_DONE);
      ad_q <= '0; sz_q <= '0; wd_q <= '0;
    end
  end

  assign status_o = st_q;
  assign access_address_o = ad_q;
  assign access_size_o = sz_q;
  assign write_data_o = wd_q;
  assign next_pc_o = pc_q;

  assign sts_o.is_resp = resp_q;
  assign sts_o.is_mul = dec.aop == AOP_MUL && dec.wr_en && !resp_q;
  assign sts_o.is_div = dec.is_div && dec.aop == AOP_MUL && dec.wr_en && !resp_q;
  assign sts_o.div_last = dcnt_q == 5'd31;
endmodule
`default_nettype wire

FILE: design/rv32_ctrl.sv
// Controller state machine sequencing capture, execute, M-unit and output.
// Uses rv32_pkg.
`default_nettype none
module rv32_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rv32_pkg::sts_t    sts_i,
  output rv32_pkg::cmd_t    cmd_o
);
  import rv32_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (sts_i.is_resp) state_d = S_OUT;
        else if (sts_i.is_div) state_d = S_DIV;
        else if (sts_i.is_mul) state_d = S_MUL;
        else state_d = S_OUT;
      end
      S_MUL:    state_d = S_DIVFIX;
      S_DIV:    if (sts_i.div_last) state_d = S_DIVFIX;
      S_DIVFIX: state_d = S_OUT;
      S_OUT:    if (out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take_in = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = !sts_i.is_resp;
        cmd_o.mul_go = !sts_i.is_resp && sts_i.is_mul && !sts_i.is_div;
        cmd_o.div_start = !sts_i.is_resp && sts_i.is_div;
      end
      S_DIV:    cmd_o.div_step = 1'b1;
      S_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.finish = out_ready_i;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/rv32imc_instruction_execute.sv
// Top level of the RV32IMC execute block: controller plus datapath.
// Uses rv32_pkg, rv32_ctrl, rv32_datapath.
`default_nettype none
// One item at a time. An item is captured, decoded and executed in the next
// cycle, and its result is then offered in S_OUT. Multiplies first pass through
// S_MUL and S_DIVFIX; divides and remainders pass through S_DIV, which runs a
// one-bit-per-cycle restoring divider, and S_DIVFIX. A result that waits for
// out_ready_i holds off the next item. Loads and stores only issue a request;
// the following response item completes the load write.
module rv32imc_instruction_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] read_data_i,
  input  logic        access_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] access_address_o,
  output logic [2:0]  access_size_o,
  output logic [31:0] write_data_o,
  output logic [31:0] next_pc_o
);
  import rv32_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rv32_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rv32_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cmd_in_i(cmd_i),
    .instruction_i, .read_data_i, .access_ok_i, .status_o, .access_address_o,
    .access_size_o, .write_data_o, .next_pc_o
  );
endmodule
`default_nettype wire

FILE: tb/rv32imc_instruction_execute_tb.sv
// Testbench for the RV32IMC execute block: directed and random instruction
// streams checked against an in-bench model of the core. Uses rv32_pkg.
`default_nettype none
module rv32imc_instruction_execute_tb;
  import rv32_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 900000;

  // Command codes that the package does not give as constants
  localparam logic CMD_RESP = 1'b1;

  typedef struct packed {
    status_e     st;
    logic [31:0] addr;
    logic [2:0]  size;
    logic [31:0] wdata;
    logic [31:0] npc;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [31:0] instruction_i = '0;
  logic [31:0] read_data_i = '0;
  logic        access_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] access_address_o;
  logic [2:0]  access_size_o;
  logic [31:0] write_data_o;
  logic [31:0] next_pc_o;

  rv32imc_instruction_execute i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Model state
  logic [31:0] regs [32];
  logic [31:0] pc_q;
  logic        pend_q;
  logic [4:0]  pend_rd;
  pkind_e      pend_kind;

  res_t expected_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned out_wait = 0;

  function automatic logic [31:0] rd_reg(input logic [4:0] i);
    return (i != 0 && i < RegCount) ? regs[i] : 32'h0;
  endfunction

  function automatic void wr_reg(input logic [4:0] i, input logic [31:0] v);
    if (i != 0 && i < RegCount) regs[i] = v;
  endfunction

  function automatic logic [31:0] alu_op(input logic [2:0] f3, input logic alt,
                                         input logic [31:0] a, input logic [31:0] b);
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << b[4:0];
      3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      3'd3: return (a < b) ? 32'd1 : 32'd0;
      3'd4: return a ^ b;
      3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] muldiv_op(input logic [2:0] f3, input logic [31:0] a,
                                            input logic [31:0] b);
    logic [63:0] sa, sb, ub, p;
    logic [31:0] ma, mb, q, r;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    ub = {32'h0, b};
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (f3)
      3'd0: return a * b;
      3'd1: begin p = sa * sb; return p[63:32]; end
      3'd2: begin p = sa * ub; return p[63:32]; end
      3'd3: begin p = {32'h0, a} * ub; return p[63:32]; end
      3'd4: begin
        if (b == 0) return '1;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
      end
      3'd5: return (b == 0) ? '1 : a / b;
      3'd6: begin
        if (b == 0) return a;
        r = ma % mb;
        return a[31] ? -r : r;
      end
      default: return (b == 0) ? a : a % b;
    endcase
  endfunction

  // Execute one item on the model and return its result
  function automatic res_t core_step(input logic cmd, input logic [31:0] ins,
                                     input logic [31:0] rdata, input logic ok);
    res_t o;
    logic [31:0] a, b, immi, imms, immb, immj, ci, jo, bo, wo, imm, t, d;
    logic [6:0] op, f7;
    logic [2:0] f3;
    logic [4:0] rd, crd, rs2c, p1, p2, ldest;
    logic take, load, store;
    pkind_e lkind;
    o = '0;
    o.st = ST_DONE;
    o.npc = pc_q;
    load = 0; store = 0; lkind = PK_LB; ldest = 0; take = 0;
    if (cmd == CMD_RESP) begin
      if (!pend_q) o.st = ST_STRAY;
      else begin
        pend_q = 0;
        if (!ok) o.st = ST_FAULT;
        else if (pend_kind != PK_ST) begin
          case (pend_kind)
            PK_LB:  d = {{24{rdata[7]}}, rdata[7:0]};
            PK_LH:  d = {{16{rdata[15]}}, rdata[15:0]};
            PK_LBU: d = {24'h0, rdata[7:0]};
            PK_LHU: d = {16'h0, rdata[15:0]};
            default: d = rdata;
          endcase
          wr_reg(pend_rd, d);
        end
      end
      return o;
    end
    pend_q = 0;
    if (ins[1:0] == 2'b11) begin
      op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25]; rd = ins[11:7];
      a = rd_reg(ins[19:15]); b = rd_reg(ins[24:20]);
      immi = {{20{ins[31]}}, ins[31:20]};
      imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      o.npc = pc_q + 4;
      case (op)
        OP_LUI:   wr_reg(rd, {ins[31:12], 12'h0});
        OP_AUIPC: wr_reg(rd, pc_q + {ins[31:12], 12'h0});
        OP_JAL: begin wr_reg(rd, pc_q + 4); o.npc = pc_q + immj; end
        OP_JALR: begin
          if (f3 != 0) o.st = ST_ILLEGAL;
          else begin o.npc = (a + immi) & ~32'h1; wr_reg(rd, pc_q + 4); end
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = $signed(a) >= $signed(b);
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: o.st = ST_ILLEGAL;
          endcase
          if (take) o.npc = pc_q + immb;
        end
        OP_LOAD: begin
          if (f3 == 3 || f3 > 5) o.st = ST_ILLEGAL;
          else begin
            load = 1; ldest = rd; o.addr = a + immi;
            lkind = pkind_e'(f3 < 3 ? f3 : f3 - 1);
            o.size = 3'(1 << f3[1:0]);
          end
        end
        OP_STORE: begin
          if (f3 > 2) o.st = ST_ILLEGAL;
          else begin store = 1; o.addr = a + imms; o.size = 3'(1 << f3); o.wdata = b; end
        end
        OP_IMM: begin
          if ((f3 == 1 && f7 != 0) || (f3 == 5 && f7 != 0 && f7 != 7'h20)) o.st = ST_ILLEGAL;
          else wr_reg(rd, alu_op(f3, f3 == 5 && f7 == 7'h20, a, immi));
        end
        OP_REG: begin
          if (f7 == 7'h01) wr_reg(rd, muldiv_op(f3, a, b));
          else if (f7 == 0) wr_reg(rd, alu_op(f3, 1'b0, a, b));
          else if (f7 == 7'h20 && (f3 == 0 || f3 == 5)) wr_reg(rd, alu_op(f3, 1'b1, a, b));
          else o.st = ST_ILLEGAL;
        end
        OP_SYSTEM: o.st = (ins == INSN_ECALL) ? ST_ECALL : ST_ILLEGAL;
        default: o.st = ST_ILLEGAL;
      endcase
    end else begin
      f3 = ins[15:13]; crd = ins[11:7]; rs2c = ins[6:2];
      p1 = {2'b01, ins[9:7]}; p2 = {2'b01, ins[4:2]};
      ci = {{26{ins[12]}}, ins[12], ins[6:2]};
      jo = {{20{ins[12]}}, ins[12], ins[8], ins[10:9], ins[6], ins[7], ins[2], ins[11],
            ins[5:3], 1'b0};
      bo = {{23{ins[12]}}, ins[12], ins[6:5], ins[2], ins[11:10], ins[4:3], 1'b0};
      wo = {25'h0, ins[5], ins[12:10], ins[6], 2'b00};
      o.npc = pc_q + 2;
      case (ins[1:0])
        2'd0: begin
          if (f3 == 0) begin
            imm = {22'h0, ins[10:7], ins[12:11], ins[5], ins[6], 2'b00};
            if (imm == 0) o.st = ST_ILLEGAL; else wr_reg(p2, rd_reg(2) + imm);
          end else if (f3 == 2) begin
            load = 1; lkind = PK_LW; ldest = p2; o.addr = rd_reg(p1) + wo; o.size = 4;
          end else if (f3 == 6) begin
            store = 1; o.addr = rd_reg(p1) + wo; o.size = 4; o.wdata = rd_reg(p2);
          end else o.st = ST_ILLEGAL;
        end
        2'd1: begin
          case (f3)
            3'd0: wr_reg(crd, rd_reg(crd) + ci);
            3'd1: begin wr_reg(1, pc_q + 2); o.npc = pc_q + jo; end
            3'd2: wr_reg(crd, ci);
            3'd3: begin
              if (crd == 2) begin
                imm = {{23{ins[12]}}, ins[12], ins[4:3], ins[5], ins[2], ins[6], 4'h0};
                if (imm == 0) o.st = ST_ILLEGAL; else wr_reg(2, rd_reg(2) + imm);
              end else begin
                imm = {{15{ins[12]}}, ins[12], ins[6:2], 12'h0};
                if (imm == 0) o.st = ST_ILLEGAL; else wr_reg(crd, imm);
              end
            end
            3'd4: begin
              case (ins[11:10])
                2'd0: if (ins[12]) o.st = ST_ILLEGAL; else wr_reg(p1, rd_reg(p1) >> rs2c);
                2'd1: if (ins[12]) o.st = ST_ILLEGAL;
                      else wr_reg(p1, 32'($signed(rd_reg(p1)) >>> rs2c));
                2'd2: wr_reg(p1, rd_reg(p1) & ci);
                default: begin
                  if (ins[12]) o.st = ST_ILLEGAL;
                  else case (ins[6:5])
                    2'd0: wr_reg(p1, rd_reg(p1) - rd_reg(p2));
                    2'd1: wr_reg(p1, rd_reg(p1) ^ rd_reg(p2));
                    2'd2: wr_reg(p1, rd_reg(p1) | rd_reg(p2));
                    default: wr_reg(p1, rd_reg(p1) & rd_reg(p2));
                  endcase
                end
              endcase
            end
            3'd5: o.npc = pc_q + jo;
            3'd6: if (rd_reg(p1) == 0) o.npc = pc_q + bo;
            default: if (rd_reg(p1) != 0) o.npc = pc_q + bo;
          endcase
        end
        default: begin
          case (f3)
            3'd0: if (crd == 0 || ins[12]) o.st = ST_ILLEGAL;
                  else wr_reg(crd, rd_reg(crd) << rs2c);
            3'd2: begin
              if (crd == 0) o.st = ST_ILLEGAL;
              else begin
                load = 1; lkind = PK_LW; ldest = crd; o.size = 4;
                o.addr = rd_reg(2) + {24'h0, ins[3:2], ins[12], ins[6:4], 2'b00};
              end
            end
            3'd4: begin
              if (rs2c != 0) begin
                if (!ins[12]) wr_reg(crd, rd_reg(rs2c));
                else wr_reg(crd, rd_reg(crd) + rd_reg(rs2c));
              end else if (crd == 0) o.st = ST_ILLEGAL;
              else begin
                t = rd_reg(crd) & ~32'h1;
                if (ins[12]) wr_reg(1, pc_q + 2);
                o.npc = t;
              end
            end
            3'd6: begin
              store = 1; o.size = 4; o.wdata = rd_reg(rs2c);
              o.addr = rd_reg(2) + {24'h0, ins[8:7], ins[12:9], 2'b00};
            end
            default: o.st = ST_ILLEGAL;
          endcase
        end
      endcase
    end
    if (load) begin
      o.st = ST_READ; pend_q = 1; pend_rd = ldest; pend_kind = lkind;
    end else if (store) begin
      o.st = ST_WRITE; pend_q = 1; pend_rd = 0; pend_kind = PK_ST;
      if (o.size == 1) o.wdata &= 32'hff;
      else if (o.size == 2) o.wdata &= 32'hffff;
    end else begin
      o.addr = 0; o.size = 0; o.wdata = 0;
    end
    pc_q = o.npc;
    return o;
  endfunction

  // Send one item: random gap, then hold valid until accepted
  task automatic send_item(input logic cmd, input logic [31:0] ins,
                           input logic [31:0] rdata, input logic ok);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    instruction_i <= ins;
    read_data_i <= rdata;
    access_ok_i <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(core_step(cmd, ins, rdata, ok));
  endtask

  task automatic send_exec(input logic [31:0] ins);
    send_item(CMD_EXEC, ins, $urandom, 1'($urandom));
  endtask

  // Answer a pending access, or send a stray one; mostly ok, sometimes a fault
  task automatic send_resp();
    send_item(CMD_RESP, $urandom, $urandom, $urandom_range(0, 7) != 0);
  endtask

  // Result checker with random back-pressure
  always @(posedge clk_i) begin
    res_t exp_r;
    int unsigned w;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d", $realtime, status_o);
        errors <= errors + 1;
      end else begin
        exp_r = expected_q.pop_front();
        if ({status_o, access_address_o, access_size_o, write_data_o, next_pc_o} !== exp_r) begin
          $display("%0t: mismatch exp st=%0d addr=%h size=%0d wd=%h pc=%h", $realtime,
                   exp_r.st, exp_r.addr, exp_r.size, exp_r.wdata, exp_r.npc);
          $display("%0t:          got st=%0d addr=%h size=%0d wd=%h pc=%h", $realtime,
                   status_o, access_address_o, access_size_o, write_data_o, next_pc_o);
          errors <= errors + 1;
        end
      end
    end
    // A fresh random wait for every result
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_wait <= $urandom_range(0, 12);
    end else if (out_valid_o && out_ready_i) begin
      w = $urandom_range(0, 12);
      out_wait <= w;
      out_ready_i <= (w == 0);
    end else if (out_valid_o && !out_ready_i) begin
      if (out_wait <= 1) out_ready_i <= 1'b1;
      if (out_wait != 0) out_wait <= out_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random R-type instruction with the given funct7 and funct3
  function automatic logic [31:0] rand_rtype(input logic [6:0] f7, input logic [2:0] f3);
    return {f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), OP_REG};
  endfunction

  // Seed the registers by LUI with random and interesting upper values
  task automatic test_reg_setup();
    logic [31:0] vals [6];
    vals = '{32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h1, 32'h0, 32'h0000_1000};
    for (int i = 1; i < 32; i++)
      send_exec({20'($urandom), 5'(i), OP_LUI});
    for (int i = 0; i < 6; i++) send_exec({vals[i][31:12] + vals[i][11], 5'(i + 1), OP_LUI});
  endtask

  task automatic test_directed();
    send_resp();                                              // stray response
    send_exec({7'h01, 5'd3, 5'd1, 3'd4, 5'd10, OP_REG});      // div of equal operands
    send_exec({7'h01, 5'd3, 5'd1, 3'd6, 5'd11, OP_REG});      // rem of equal operands
    send_exec({7'h01, 5'd0, 5'd2, 3'd5, 5'd12, OP_REG});      // divide by zero
    send_exec({7'h01, 5'd0, 5'd2, 3'd7, 5'd13, OP_REG});      // remu by zero
    send_exec(INSN_ECALL);
    send_exec(32'h0010_0073);                                 // ebreak
    send_exec(32'h0000_000f);                                 // fence
    send_exec(32'h0000_0000);                                 // zero C.ADDI4SPN
    send_exec(32'h0000_8082);                                 // C.JR x1
    send_exec(32'h0000_8002);                                 // C.JR x0: illegal
    send_exec(32'h0000_1002);                                 // C.SLLI shamt bit 5
    send_exec(32'h0000_9c01);                                 // RV64-only C.SUBW
    send_exec({12'h7ff, 5'd2, 3'd4, 5'd5, OP_LOAD});          // LBU
    send_resp();
    send_exec({12'h800, 5'd2, 3'd1, 5'd6, OP_LOAD});          // LH
    send_exec({7'h7f, 5'd2, 5'd2, 3'd0, 5'd1, OP_STORE});     // abandon load
    send_item(CMD_RESP, 32'h0, 32'hffff_ffff, 1'b0);          // fault
    send_exec({12'h001, 5'd5, 3'd0, 5'd0, OP_JALR});          // jump clears bit 0
    send_exec(32'hffff_ffff);
  endtask

  task automatic test_random();
    logic [31:0] ins;
    int unsigned pick;
    for (int n = 0; n < 680; n++) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0, 1, 2: ins = rand_rtype($urandom_range(0, 1) ? 7'h01 : 7'h00, 3'($urandom));
        3: ins = rand_rtype(7'h20, $urandom_range(0, 1) ? 3'd0 : 3'd5);
        4, 5: ins = {12'($urandom), 5'($urandom), 3'($urandom), 5'($urandom), OP_IMM};
        6: ins = {12'($urandom), 5'($urandom), 3'($urandom), 5'($urandom), OP_LOAD};
        7: ins = {7'($urandom), 5'($urandom), 5'($urandom), 3'($urandom_range(0, 3)),
                  5'($urandom), OP_STORE};
        8: ins = {25'($urandom), $urandom_range(0, 1) ? OP_BRANCH : OP_JAL};
        9: ins = {25'($urandom), $urandom_range(0, 1) ? OP_LUI : OP_AUIPC};
        10: ins = {17'($urandom), 3'($urandom_range(0, 1)), 5'($urandom), OP_JALR};
        11, 12, 13, 14, 15: ins = {16'($urandom), 16'($urandom) | 16'h0}
                                 & (($urandom_range(0, 2) == 0) ? 32'hffff_fffc : '1);
        16: ins = $urandom;
        default: ins = {7'h01, 5'($urandom), 5'($urandom), 3'($urandom), 5'($urandom), OP_REG};
      endcase
      if (ins[1:0] == 2'b11 && pick >= 11 && pick <= 15) ins[1:0] = 2'($urandom_range(0, 2));
      send_exec(ins);
      if (pend_q && $urandom_range(0, 9) != 0) send_resp();
      else if ($urandom_range(0, 30) == 0) send_resp();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 32; i++) regs[i] = '0;
    pc_q = '0; pend_q = 0; pend_rd = '0; pend_kind = PK_LB;
    @(posedge clk_i);
    test_reg_setup();
    test_directed();
    test_random();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
design/rv32_pkg.sv
design/rv32_decode.sv
design/rv32_datapath.sv
design/rv32_ctrl.sv
design/rv32imc_instruction_execute.sv
tb/rv32imc_instruction_execute_tb.sv
